// ===== src/curl_magnitude_3d_volume_defines.svh =====
// ---------------------------------------------------------------------------
// curl magnitude assertion macros
// shared concurrent checks for the vorticity block, clocked on clk, off in reset
// ---------------------------------------------------------------------------
`ifndef CURL_MAGNITUDE_3D_VOLUME_DEFINES_SVH
`define CURL_MAGNITUDE_3D_VOLUME_DEFINES_SVH

// same-cycle implication
`define CMV_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("curl magnitude check failed");

// next-cycle implication
`define CMV_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("curl magnitude check failed");

`endif

// ===== src/cmv_pkg.sv =====
// ---------------------------------------------------------------------------
// cmv package
// widths, register codes and the job and geometry types of the curl block
// ---------------------------------------------------------------------------
package cmv_pkg;

  localparam int SIZE_W      = 7;
  localparam int PLANE_W     = 14;
  localparam int COUNT_W     = 21;
  localparam int INDEX_W     = 18;
  localparam int MAG_W       = 19;
  localparam int RAD_W       = 38;
  localparam int FIELD_W     = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int CNT_W       = 5;

  localparam logic [1:0] REG_SIZE_SLOW = 2'd0;
  localparam logic [1:0] REG_SIZE_MID  = 2'd1;
  localparam logic [1:0] REG_SIZE_FAST = 2'd2;

  // strides the back end needs for neighbour addresses
  typedef struct packed {
    logic [PLANE_W-1:0] plane;
    logic [SIZE_W-1:0]  size_fast;
  } geom_t;

  // one voxel to evaluate; bit 0 slow axis, bit 1 mid, bit 2 fast
  typedef struct packed {
    logic [2:0]         at_first;
    logic [2:0]         at_last;
    logic [INDEX_W-1:0] voxel_index;
    logic               last_voxel;
  } job_t;

endpackage

// ===== src/curl_magnitude_3d_volume.sv =====
// ---------------------------------------------------------------------------
// curl magnitude of a 3d velocity volume
// streams voxels in raster order and returns the vorticity magnitude of each
// ---------------------------------------------------------------------------
// usage:
//   in_*  : one word per velocity sample (tuser=0) or flush tick (tuser=1);
//           samples arrive slow axis outermost, fast axis innermost
//   out_* : one word per voxel, curl magnitude in unsigned q.1 with its raster
//           index; tlast marks the final voxel of the volume
//   cfg_* : three size registers at 0x0, 0x4, 0x8; a write restarts the stream
// a voxel becomes ready once its forward neighbour sample is in, so the first
// result follows one plane plus one sample of input; flush ticks drain the
// last plane
// each voxel passes through the back end in turn: queue pop, ring reads of
// its neighbours, curl, square and sum, the bit-serial root and the hand-off;
// the back end takes the next voxel only once the last one is handed off.
// samples that produce no voxel (the first plane) go in at one a cycle while
// the job queue has room
// the front end runs ahead of the back end through a four-deep job queue and
// stalls in_tready only when that queue is full; a stalled receiver holds the
// result register and the back end waits, the front keeps filling the queue
// reset clears all counters and sets each size to 64 (or MAX_DIM if smaller);
// the ring store holds no reset and needs no clearing pass
// ---------------------------------------------------------------------------
`include "curl_magnitude_3d_volume_defines.svh"

module curl_magnitude_3d_volume import cmv_pkg::*; #(
  parameter int MAX_DIM   = 64,
  parameter int COMP_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // vel_x[15:0], vel_y[31:16], vel_z[47:32]
  input  logic        in_tuser,   // kind[0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // curl_magnitude[18:0], voxel_index[36:19], zero[39:37]
  output logic        out_tlast
);

  // ring covers the two-plane window plus front-end run-ahead across volumes
  localparam int RING_AW = $clog2(4 * MAX_DIM * MAX_DIM);
  localparam int QW      = $bits(job_t) + RING_AW;

  geom_t                  geom;
  logic                   ring_we;
  logic [RING_AW-1:0]     ring_wa;
  logic [3*COMP_BITS-1:0] ring_wd;
  logic                   q_push, q_full, q_pop, q_empty;
  job_t                   push_job, pop_job;
  logic [RING_AW-1:0]     push_addr, pop_addr;

  assign cfg_pready = 1'b1;

  cmv_front #(
    .MAX_DIM   (MAX_DIM),
    .COMP_BITS (COMP_BITS),
    .RING_AW   (RING_AW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .geom        (geom),
    .ring_we     (ring_we),
    .ring_wa     (ring_wa),
    .ring_wd     (ring_wd),
    .q_push      (q_push),
    .q_full      (q_full),
    .q_job       (push_job),
    .q_addr      (push_addr)
  );

  // job queue: voxel descriptor plus ring address of its center sample
  cmv_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   ({push_job, push_addr}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  ({pop_job, pop_addr}),
    .empty (q_empty)
  );

  cmv_back #(
    .COMP_BITS (COMP_BITS),
    .RING_AW   (RING_AW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ring_we    (ring_we),
    .ring_wa    (ring_wa),
    .ring_wd    (ring_wd),
    .geom       (geom),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_job      (pop_job),
    .q_addr     (pop_addr),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // queue never overflows or underflows
  `CMV_ASSERT_IMP(a_push_not_full, q_push, !q_full)
  `CMV_ASSERT_IMP(a_pop_not_empty, q_pop, !q_empty)
  // a result only leaves once taken
  `CMV_ASSERT_NXT(a_out_held, out_tvalid && !out_tready, out_tvalid)
  // a word is only accepted while the queue has room
  `CMV_ASSERT_IMP(a_ready_tracks_queue, q_full, !in_tready)

endmodule

// ===== src/cmv_queue.sv =====
// ---------------------------------------------------------------------------
// cmv job queue
// short register fifo between the front end and the back end
// ---------------------------------------------------------------------------
module cmv_queue import cmv_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [W-1:0]  mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full  = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// ===== src/cmv_front.sv =====
// ---------------------------------------------------------------------------
// cmv front end
// register port, sample intake into the ring and emit scheduling
// ---------------------------------------------------------------------------
module cmv_front import cmv_pkg::*; #(
  parameter int MAX_DIM   = 64,
  parameter int COMP_BITS = 16,
  parameter int RING_AW   = 14
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [3:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [47:0]            in_tdata,
  input  logic                   in_tuser,
  output geom_t                  geom,
  output logic                   ring_we,
  output logic [RING_AW-1:0]     ring_wa,
  output logic [3*COMP_BITS-1:0] ring_wd,
  output logic                   q_push,
  input  logic                   q_full,
  output job_t                   q_job,
  output logic [RING_AW-1:0]     q_addr
);

  localparam int RS       = (MAX_DIM < 64) ? MAX_DIM : 64;
  localparam int RS_PLANE = RS * RS;
  localparam int RS_TOTAL = RS * RS * RS;

  logic [SIZE_W-1:0]  size_slow_r, size_mid_r, size_fast_r;
  logic [SIZE_W-1:0]  slow_nxt, mid_nxt, fast_nxt;
  logic [PLANE_W-1:0] plane_r;
  logic [COUNT_W-1:0] total_r, arrived_r, e_r;
  logic [SIZE_W-1:0]  es_r, em_r, ef_r;
  logic [RING_AW-1:0] wr_ptr_r, base_r;

  logic               cfg_wr, cfg_hit, acc, take, emit, last;
  logic [SIZE_W-1:0]  wv;
  logic [COUNT_W-1:0] c_new, need;
  logic [SIZE_W:0]    es1, em1, ef1;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v < SIZE_W'(2)) r = SIZE_W'(2);
    else if (int'(v) > MAX_DIM) r = SIZE_W'(MAX_DIM);
    return r;
  endfunction

  // register port
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign wv     = clamp_size(cfg_pwdata[SIZE_W-1:0]);

  always_comb begin
    slow_nxt = size_slow_r;
    mid_nxt  = size_mid_r;
    fast_nxt = size_fast_r;
    cfg_hit  = 1'b0;
    if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_SIZE_SLOW: begin slow_nxt = wv; cfg_hit = 1'b1; end
        REG_SIZE_MID:  begin mid_nxt  = wv; cfg_hit = 1'b1; end
        REG_SIZE_FAST: begin fast_nxt = wv; cfg_hit = 1'b1; end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_SIZE_SLOW: cfg_prdata = {25'b0, size_slow_r};
      REG_SIZE_MID:  cfg_prdata = {25'b0, size_mid_r};
      REG_SIZE_FAST: cfg_prdata = {25'b0, size_fast_r};
      default:       cfg_prdata = '0;
    endcase
  end

  assign geom.plane     = plane_r;
  assign geom.size_fast = size_fast_r;

  // sample intake
  assign in_tready = ~q_full;
  assign acc       = in_tvalid & in_tready;
  assign take      = acc & ~in_tuser & (arrived_r < total_r);
  assign c_new     = arrived_r + COUNT_W'(take);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < COMP_BITS; i++) begin
        ring_wd[k*COMP_BITS+i] = (i < FIELD_W) ? in_tdata[k*FIELD_W + ((i < FIELD_W) ? i : 0)]
                                               : 1'b0;
      end
    end
  end

  assign ring_we = take;
  assign ring_wa = wr_ptr_r;

  // forward neighbour that must be in before the voxel can go
  assign es1 = {1'b0, es_r} + 1'b1;
  assign em1 = {1'b0, em_r} + 1'b1;
  assign ef1 = {1'b0, ef_r} + 1'b1;

  always_comb begin
    if (es1 < {1'b0, size_slow_r})      need = e_r + COUNT_W'(plane_r);
    else if (em1 < {1'b0, size_mid_r})  need = e_r + COUNT_W'(size_fast_r);
    else if (ef1 < {1'b0, size_fast_r}) need = e_r + COUNT_W'(1);
    else                                need = e_r;
  end

  assign emit = acc & (e_r < total_r) & (need < c_new);
  assign last = ((e_r + COUNT_W'(1)) == total_r);

  assign q_push               = emit;
  assign q_addr               = base_r + e_r[RING_AW-1:0];
  assign q_job.at_first       = {ef_r == '0, em_r == '0, es_r == '0};
  assign q_job.at_last        = {ef1 >= {1'b0, size_fast_r}, em1 >= {1'b0, size_mid_r},
                                 es1 >= {1'b0, size_slow_r}};
  assign q_job.voxel_index    = e_r[INDEX_W-1:0];
  assign q_job.last_voxel     = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_slow_r <= SIZE_W'(RS);
      size_mid_r  <= SIZE_W'(RS);
      size_fast_r <= SIZE_W'(RS);
      plane_r     <= PLANE_W'(RS_PLANE);
      total_r     <= COUNT_W'(RS_TOTAL);
      arrived_r   <= '0;
      e_r         <= '0;
      es_r        <= '0;
      em_r        <= '0;
      ef_r        <= '0;
      wr_ptr_r    <= '0;
      base_r      <= '0;
    end else if (cfg_hit) begin
      // a size write restarts the stream
      size_slow_r <= slow_nxt;
      size_mid_r  <= mid_nxt;
      size_fast_r <= fast_nxt;
      plane_r     <= PLANE_W'(mid_nxt) * PLANE_W'(fast_nxt);
      total_r     <= COUNT_W'(mid_nxt) * COUNT_W'(fast_nxt) * COUNT_W'(slow_nxt);
      arrived_r   <= '0;
      e_r         <= '0;
      es_r        <= '0;
      em_r        <= '0;
      ef_r        <= '0;
      base_r      <= wr_ptr_r;
    end else begin
      if (take) wr_ptr_r <= wr_ptr_r + 1'b1;
      // the final voxel going out restarts the count for the next volume
      arrived_r <= (emit && last) ? '0 : c_new;
      if (emit) begin
        if (last) begin
          e_r       <= '0;
          es_r      <= '0;
          em_r      <= '0;
          ef_r      <= '0;
          base_r    <= wr_ptr_r + RING_AW'(take);
        end else begin
          e_r <= e_r + 1'b1;
          if (ef1 >= {1'b0, size_fast_r}) begin
            ef_r <= '0;
            if (em1 >= {1'b0, size_mid_r}) begin
              em_r <= '0;
              es_r <= es_r + 1'b1;
            end else begin
              em_r <= em_r + 1'b1;
            end
          end else begin
            ef_r <= ef_r + 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== src/cmv_back.sv =====
// ---------------------------------------------------------------------------
// cmv back end
// ring store, neighbour fetch, curl, sum of squares and bit-serial root
// ---------------------------------------------------------------------------
module cmv_back import cmv_pkg::*; #(
  parameter int COMP_BITS = 16,
  parameter int RING_AW   = 14
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   ring_we,
  input  logic [RING_AW-1:0]     ring_wa,
  input  logic [3*COMP_BITS-1:0] ring_wd,
  input  geom_t                  geom,
  input  logic                   q_empty,
  output logic                   q_pop,
  input  job_t                   q_job,
  input  logic [RING_AW-1:0]     q_addr,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [39:0]            out_tdata,
  output logic                   out_tlast
);

  localparam int SW_  = 3 * COMP_BITS;
  localparam int CW   = COMP_BITS + 3;
  localparam int PW   = 2 * CW;
  localparam int AW   = PW + 2;
  localparam int XW   = (AW > RAD_W) ? AW : RAD_W;
  localparam int REM_W = MAG_W + 3;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_CALC = 6'b000100,
    ST_SQR  = 6'b001000,
    ST_ROOT = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t                   state_r;
  job_t                     job_r;
  logic [RING_AW-1:0]       ctr_r, rd_addr, stride;
  logic [CNT_W-1:0]         cnt_r;
  logic [SW_-1:0]           ring [2**RING_AW];
  logic [SW_-1:0]           rd_data_r;
  logic [SW_-1:0]           samp_r [6];
  logic signed [CW-1:0]     curl_r [3];
  logic signed [CW-1:0]     curl_nxt [3];
  logic [PW-1:0]            prod_r;
  logic signed [PW-1:0]     prod_s;
  logic [AW-1:0]            acc_r;
  logic [XW-1:0]            sum_w;
  logic [RAD_W-1:0]         rad_r, rad_nxt;
  logic [REM_W-1:0]         rem_r, rem_sh, trial;
  logic [MAG_W-1:0]         root_r;
  logic [1:0]               sq_sel;
  logic [31:0]              plane_w, fast_w;
  logic                     edge_f, edge_b, out_load;
  logic signed [COMP_BITS+1:0] grad [3][3];
  logic [39:0]              out_data_r;
  logic                     out_valid_r, out_last_r;

  // ring store: front end writes, one neighbour read a cycle
  always_ff @(posedge clk) begin
    if (ring_we) ring[ring_wa] <= ring_wd;
    rd_data_r <= ring[rd_addr];
  end

  assign plane_w = {18'b0, geom.plane};
  assign fast_w  = {25'b0, geom.size_fast};

  // neighbour address: even count is forward, odd is backward
  always_comb begin
    case (cnt_r[2:1])
      2'd0: begin
        stride = plane_w[RING_AW-1:0];
        edge_f = job_r.at_last[0];
        edge_b = job_r.at_first[0];
      end
      2'd1: begin
        stride = fast_w[RING_AW-1:0];
        edge_f = job_r.at_last[1];
        edge_b = job_r.at_first[1];
      end
      default: begin
        stride = RING_AW'(1);
        edge_f = job_r.at_last[2];
        edge_b = job_r.at_first[2];
      end
    endcase
    if (cnt_r[0]) rd_addr = edge_b ? ctr_r : ctr_r - stride;
    else          rd_addr = edge_f ? ctr_r : ctr_r + stride;
  end

  // gradients in half units: one-sided counts twice
  always_comb begin
    logic signed [COMP_BITS:0] d;
    for (int a = 0; a < 3; a++) begin
      for (int c = 0; c < 3; c++) begin
        d = $signed({samp_r[2*a][c*COMP_BITS + COMP_BITS-1], samp_r[2*a][c*COMP_BITS +: COMP_BITS]})
          - $signed({samp_r[2*a+1][c*COMP_BITS + COMP_BITS-1],
                     samp_r[2*a+1][c*COMP_BITS +: COMP_BITS]});
        grad[a][c] = (job_r.at_first[a] | job_r.at_last[a]) ? {d, 1'b0} : {d[COMP_BITS], d};
      end
    end
    curl_nxt[0] = CW'(grad[1][2]) - CW'(grad[2][1]);
    curl_nxt[1] = CW'(grad[2][0]) - CW'(grad[0][2]);
    curl_nxt[2] = CW'(grad[0][1]) - CW'(grad[1][0]);
  end

  assign sq_sel = (cnt_r[1:0] == 2'd3) ? 2'd0 : cnt_r[1:0];
  assign prod_s = curl_r[sq_sel] * curl_r[sq_sel];
  assign sum_w  = XW'(acc_r) + XW'(prod_r);
  assign rad_nxt = (sum_w > XW'({RAD_W{1'b1}})) ? {RAD_W{1'b1}} : sum_w[RAD_W-1:0];

  // one root bit a cycle
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1:RAD_W-2]};
  assign trial  = {1'b0, root_r, 2'b01};

  assign q_pop    = (state_r == ST_IDLE) & ~q_empty;
  assign out_load = (state_r == ST_DONE) & (~out_valid_r | out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (!q_empty) begin
          state_r <= ST_READ;
          cnt_r   <= '0;
        end
        ST_READ: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(6)) state_r <= ST_CALC;
        end
        ST_CALC: begin
          state_r <= ST_SQR;
          cnt_r   <= '0;
        end
        ST_SQR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(3)) begin
            state_r <= ST_ROOT;
            cnt_r   <= '0;
          end
        end
        ST_ROOT: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(MAG_W-1)) state_r <= ST_DONE;
        end
        ST_DONE: if (out_load) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
      ctr_r <= q_addr;
    end
    if (state_r == ST_READ && cnt_r != '0) samp_r[cnt_r[2:0] - 3'd1] <= rd_data_r;
    if (state_r == ST_CALC) begin
      for (int k = 0; k < 3; k++) curl_r[k] <= curl_nxt[k];
    end
    if (state_r == ST_SQR) begin
      prod_r <= prod_s;
      acc_r  <= (cnt_r == '0) ? '0 : sum_w[AW-1:0];
      if (cnt_r == CNT_W'(3)) begin
        rad_r  <= rad_nxt;
        rem_r  <= '0;
        root_r <= '0;
      end
    end
    if (state_r == ST_ROOT) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[MAG_W-2:0], 1'b0};
      end
    end
    if (out_load) begin
      out_data_r <= {3'b0, job_r.voxel_index, root_r};
      out_last_r <= job_r.last_voxel;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
